// ===== design/pfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsp_pkg
// Shared types, character codes and helper functions for the format spec
// parser.
// ----------------------------------------------------------------------------
package pfsp_pkg;

	typedef enum logic [3:0] {
		PH_PLAIN    = 4'd0,
		PH_PCT      = 4'd1,
		PH_FLAGS    = 4'd2,
		PH_WDIG     = 4'd3,
		PH_WSTAR    = 4'd4,
		PH_DOT      = 4'd5,
		PH_PDIG     = 4'd6,
		PH_PSTAR    = 4'd7,
		PH_LEN_H    = 4'd8,
		PH_LEN_L    = 4'd9,
		PH_LEN_DONE = 4'd10,
		PH_ERROR    = 4'd11
	} phase_t;

	localparam logic [2:0] CLASS_INT   = 3'd0;
	localparam logic [2:0] CLASS_UINT  = 3'd1;
	localparam logic [2:0] CLASS_FLOAT = 3'd2;
	localparam logic [2:0] CLASS_STR   = 3'd3;
	localparam logic [2:0] CLASS_PTR   = 3'd4;
	localparam logic [2:0] CLASS_NONE  = 3'd7;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_LC_L  = 8'h6c;
	localparam logic [7:0] CH_LC_H  = 8'h68;
	localparam logic [7:0] CH_UC_L  = 8'h4c;
	localparam logic [7:0] CH_LC_Z  = 8'h7a;
	localparam logic [7:0] CH_LC_J  = 8'h6a;
	localparam logic [7:0] CH_LC_T  = 8'h74;

	typedef struct packed {
		logic       conv_valid;
		logic [2:0] expect_class;
		logic [7:0] conv_char;
		logic       done_res;
		logic       format_ok;
	} result_t;

	typedef struct packed {
		phase_t  next_phase;
		logic    emit;
		result_t res;
	} step_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_flag(input logic [7:0] c);
		return (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SPACE) ||
			(c == CH_HASH) || (c == CH_ZERO);
	endfunction

	function automatic logic [2:0] conv_class(input logic [7:0] c);
		logic [2:0] k;
		unique case (c)
			8'h64, 8'h69, 8'h63:                             k = CLASS_INT;
			8'h75, 8'h6f, 8'h78, 8'h58:                      k = CLASS_UINT;
			8'h66, 8'h46, 8'h65, 8'h45,
			8'h67, 8'h47, 8'h61, 8'h41:                      k = CLASS_FLOAT;
			8'h73:                                           k = CLASS_STR;
			8'h70, 8'h6e:                                    k = CLASS_PTR;
			default:                                         k = CLASS_NONE;
		endcase
		return k;
	endfunction

endpackage

// ===== design/pfsp_if.sv =====
// ----------------------------------------------------------------------------
// pfsp_if
// Valid/ready channels: format bytes in, parse results out.
// ----------------------------------------------------------------------------
interface pfsp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last_char;

	modport source (output valid, ch, last_char, input ready);
	modport sink   (input valid, ch, last_char, output ready);
endinterface

interface pfsp_res_if;
	logic       valid;
	logic       ready;
	logic       conv_valid;
	logic [2:0] expect_class;
	logic [7:0] conv_char;
	logic       done_res;
	logic       format_ok;

	modport source (output valid, conv_valid, expect_class, conv_char, done_res, format_ok,
		input ready);
	modport sink   (input valid, conv_valid, expect_class, conv_char, done_res, format_ok,
		output ready);
endinterface

// ===== design/pfsp_step.sv =====
// ----------------------------------------------------------------------------
// pfsp_step
// Phase transition and conversion classification for one format byte.
// ----------------------------------------------------------------------------
module pfsp_step (
	input  pfsp_pkg::phase_t phase,
	input  logic [7:0]       ch,
	input  logic             last_char,
	output pfsp_pkg::step_t  step
);

	pfsp_pkg::phase_t nxt;
	logic [2:0]       cls;
	logic [2:0]       k;
	logic             in_pre;

	always_comb begin
		nxt    = pfsp_pkg::PH_ERROR;
		cls    = pfsp_pkg::CLASS_NONE;
		k      = pfsp_pkg::conv_class(ch);
		in_pre = (phase == pfsp_pkg::PH_PCT) || (phase == pfsp_pkg::PH_FLAGS);
		priority if (phase == pfsp_pkg::PH_ERROR) begin
			nxt = pfsp_pkg::PH_ERROR;
		end else if (phase == pfsp_pkg::PH_PLAIN) begin
			nxt = (ch == pfsp_pkg::CH_PCT) ? pfsp_pkg::PH_PCT : pfsp_pkg::PH_PLAIN;
		end else if (phase == pfsp_pkg::PH_PCT && ch == pfsp_pkg::CH_PCT) begin
			nxt = pfsp_pkg::PH_PLAIN;
		end else if (phase > pfsp_pkg::PH_LEN_DONE) begin
			nxt = pfsp_pkg::PH_ERROR;
		end else if (in_pre && pfsp_pkg::is_flag(ch)) begin
			nxt = pfsp_pkg::PH_FLAGS;
		end else if (in_pre && ch == pfsp_pkg::CH_STAR) begin
			nxt = pfsp_pkg::PH_WSTAR;
		end else if (in_pre && pfsp_pkg::is_digit(ch)) begin
			nxt = pfsp_pkg::PH_WDIG;
		end else if (phase == pfsp_pkg::PH_WDIG && pfsp_pkg::is_digit(ch)) begin
			nxt = pfsp_pkg::PH_WDIG;
		end else if (phase <= pfsp_pkg::PH_WSTAR && ch == pfsp_pkg::CH_DOT) begin
			nxt = pfsp_pkg::PH_DOT;
		end else if (phase == pfsp_pkg::PH_DOT && ch == pfsp_pkg::CH_STAR) begin
			nxt = pfsp_pkg::PH_PSTAR;
		end else if (phase == pfsp_pkg::PH_DOT && pfsp_pkg::is_digit(ch)) begin
			nxt = pfsp_pkg::PH_PDIG;
		end else if (phase == pfsp_pkg::PH_PDIG && pfsp_pkg::is_digit(ch)) begin
			nxt = pfsp_pkg::PH_PDIG;
		end else if (phase <= pfsp_pkg::PH_PSTAR && ch == pfsp_pkg::CH_LC_H) begin
			nxt = pfsp_pkg::PH_LEN_H;
		end else if (phase <= pfsp_pkg::PH_PSTAR && ch == pfsp_pkg::CH_LC_L) begin
			nxt = pfsp_pkg::PH_LEN_L;
		end else if (phase <= pfsp_pkg::PH_PSTAR &&
			(ch == pfsp_pkg::CH_UC_L || ch == pfsp_pkg::CH_LC_Z ||
			 ch == pfsp_pkg::CH_LC_J || ch == pfsp_pkg::CH_LC_T)) begin
			nxt = pfsp_pkg::PH_LEN_DONE;
		end else if (phase == pfsp_pkg::PH_LEN_H && ch == pfsp_pkg::CH_LC_H) begin
			nxt = pfsp_pkg::PH_LEN_DONE;
		end else if (phase == pfsp_pkg::PH_LEN_L && ch == pfsp_pkg::CH_LC_L) begin
			nxt = pfsp_pkg::PH_LEN_DONE;
		end else if (k == pfsp_pkg::CLASS_NONE) begin
			nxt = pfsp_pkg::PH_ERROR;
		end else begin
			cls = k;
			nxt = pfsp_pkg::PH_PLAIN;
		end
	end

	always_comb begin
		step.next_phase       = last_char ? pfsp_pkg::PH_PLAIN : nxt;
		step.emit             = last_char || (cls != pfsp_pkg::CLASS_NONE);
		step.res.conv_valid   = (cls != pfsp_pkg::CLASS_NONE);
		step.res.expect_class = (cls != pfsp_pkg::CLASS_NONE) ? cls : pfsp_pkg::CLASS_INT;
		step.res.conv_char    = (cls != pfsp_pkg::CLASS_NONE) ? ch : 8'h00;
		step.res.done_res     = last_char;
		step.res.format_ok    = last_char && (nxt == pfsp_pkg::PH_PLAIN);
	end

endmodule

// ===== design/pfsp_out_stage.sv =====
// ----------------------------------------------------------------------------
// pfsp_out_stage
// Result register driving the output channel; holds a word while stalled.
// ----------------------------------------------------------------------------
module pfsp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  pfsp_pkg::result_t res_in,
	output logic              slot_free,
	pfsp_res_if.source        res
);

	logic              valid_q;
	pfsp_pkg::result_t res_q;

	assign slot_free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && load) begin
			res_q <= res_in;
		end
	end

	assign res.valid        = valid_q;
	assign res.conv_valid   = res_q.conv_valid;
	assign res.expect_class = res_q.expect_class;
	assign res.conv_char    = res_q.conv_char;
	assign res.done_res     = res_q.done_res;
	assign res.format_ok    = res_q.format_ok;

endmodule

// ===== design/printf_format_spec_parser.sv =====
// ----------------------------------------------------------------------------
// printf_format_spec_parser
// Parses a printf format string one byte per word and reports conversions.
//
// fmt carries one byte of the string per word, last_char set on the final
// byte. res carries at most one word per byte: one for each byte that ends
// a conversion spec, and one for the final byte with done_res and format_ok.
// Bytes that produce nothing are absorbed without an output word.
// A byte's result passes through the input register, then the phase update
// and the result register. Throughput: one byte per cycle while res is not
// stalled; the phase update sits between the two registers.
// When res stalls, the result register holds its word and fmt.ready drops
// once the input register is also full; nothing is lost or repeated.
// Reset clears both valid flags and returns the parser to plain text.
// The phase also returns to plain text after every final byte, so strings
// may follow one another back to back.
// ----------------------------------------------------------------------------
module printf_format_spec_parser (
	input  logic        clk,
	input  logic        arst_n,
	pfsp_char_if.sink   fmt,
	pfsp_res_if.source  res
);

	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             last_s1;
	pfsp_pkg::phase_t phase_q;
	pfsp_pkg::step_t  step;
	logic             slot_free;
	logic             advance;

	assign advance   = valid_s1 && slot_free;
	assign fmt.ready = !valid_s1 || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fmt.ready) begin
			valid_s1 <= fmt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fmt.ready && fmt.valid) begin
			ch_s1   <= fmt.ch;
			last_s1 <= fmt.last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pfsp_pkg::PH_PLAIN;
		end else if (advance) begin
			phase_q <= step.next_phase;
		end
	end

	pfsp_step u_step (
		.phase     (phase_q),
		.ch        (ch_s1),
		.last_char (last_s1),
		.step      (step)
	);

	pfsp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && step.emit),
		.res_in    (step.res),
		.slot_free (slot_free),
		.res       (res)
	);

endmodule

// ===== design/pfsp_checker.sv =====
// ----------------------------------------------------------------------------
// pfsp_checker
// Port-level checks on the parser's result channel.
// ----------------------------------------------------------------------------
module pfsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       conv_valid,
	input logic [2:0] expect_class,
	input logic [7:0] conv_char,
	input logic       done_res,
	input logic       format_ok
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && conv_valid |-> expect_class <= pfsp_pkg::CLASS_PTR)
		else $error("conversion with unknown class");

	a_why: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !conv_valid |-> done_res)
		else $error("word with neither conversion nor done");

	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && format_ok |-> done_res)
		else $error("format_ok without done");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !conv_valid |-> expect_class == pfsp_pkg::CLASS_INT && conv_char == 8'h00)
		else $error("stale conversion fields");

endmodule

bind printf_format_spec_parser pfsp_checker u_pfsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.conv_valid   (res.conv_valid),
	.expect_class (res.expect_class),
	.conv_char    (res.conv_char),
	.done_res     (res.done_res),
	.format_ok    (res.format_ok)
);
